// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LFSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset
`define LFSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/lfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared constants, codes and types of the lowest free slot allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

   // Pool geometry
   localparam int SLOTS  = 256;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int WORD_W = 8;
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int OUT_W  = (CNT_W > 9) ? CNT_W : 9;

   localparam logic [CNT_W-1:0] NO_HINT     = CNT_W'(SLOTS);
   localparam logic [OUT_W-1:0] SLOTS_WIDE  = OUT_W'(SLOTS);
   localparam logic [8:0]       FULL_LENGTH = SLOTS_WIDE[8:0];

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_DONE         = 2'd0,
      STATUS_FULL         = 2'd1,
      STATUS_NOT_OCCUPIED = 2'd2
   } status_type;

   // Request to the shared free-bit search unit
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [CNT_W-1:0]  base;
      logic [BIT_W:0]    start;
      logic [CNT_W-1:0]  limit;
   } find_req_type;

   // Result of the free-bit search
   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] slot;
   } find_rsp_type;

endpackage

// ----- rtl/core/lfsa_if.sv -----
// ----------------------------------------------------------------------------
// lfsa_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface lfsa_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] slot_index;

   modport source (output valid, output command, output slot_index, input ready);
   modport sink   (input valid, input command, input slot_index, output ready);
endinterface

interface lfsa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] granted_slot;
   logic [1:0] status;
   logic [8:0] used_length;
   logic [8:0] live_count;

   modport source (output valid, output granted_slot, output status,
                   output used_length, output live_count, input ready);
   modport sink   (input valid, input granted_slot, input status,
                   input used_length, input live_count, output ready);
endinterface

// ----- rtl/core/lfsa_ram.sv -----
// ----------------------------------------------------------------------------
// lfsa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/core/lfsa_find.sv -----
// ----------------------------------------------------------------------------
// lfsa_find
// Shared search unit: lowest free bit of one map word, from a start bit
// and below a slot limit.
// ----------------------------------------------------------------------------
module lfsa_find (
   input  lfsa_pkg::find_req_type find_req,
   output lfsa_pkg::find_rsp_type find_rsp
);
   import lfsa_pkg::*;

   logic             hit;
   logic [BIT_W-1:0] hit_bit;
   logic [CNT_W:0]   cand;

   // Scan top down so the lowest eligible bit wins
   always_comb begin
      hit     = 1'b0;
      hit_bit = '0;
      cand    = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         cand = {1'b0, find_req.base} + (CNT_W + 1)'(b);
         if (!find_req.word[b] && ((BIT_W + 1)'(b) >= find_req.start) &&
             (cand < {1'b0, find_req.limit})) begin
            hit     = 1'b1;
            hit_bit = BIT_W'(b);
         end
      end
   end

   assign find_rsp.found = hit;
   assign find_rsp.slot  = find_req.base + CNT_W'(hit_bit);

endmodule

// ----- rtl/core/lowest_free_slot_allocator.sv -----
// A full pool goes straight to the response; an append, a free or an
// allocate reads the target's 8-slot map word and updates it, and an allocate
// whose next free slot is not in it scans upward through further map words
// below the length mark (up to 31). The next request is taken once the
// response is loaded, so one waiting response does not block the input.
// Reset: synchronous, clears counters, hint and row valid bits (no sweep).
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator
// Hands out the lowest free slot below the length mark, appends otherwise,
// and takes slots back, keeping the occupancy map in a word-wide RAM.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator (
   input  logic       clock,
   input  logic       reset,
   lfsa_req_if.sink   req_bus,
   lfsa_rsp_if.source rsp_bus
);
   import lfsa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MODIFY = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   command_type      cmd_ff, cmd_in;
   status_type       status_ff, status_in;
   logic             append_ff, append_in;
   logic [CNT_W-1:0] tgt_ff, tgt_in;
   logic [ROW_W-1:0] scan_row_ff, scan_row_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] hint_ff, hint_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [ROWS-1:0]  row_valid_ff;
   logic             rd_valid_ff;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_granted_ff;
   logic [1:0]       rsp_status_ff;
   logic [8:0]       rsp_used_ff;
   logic [8:0]       rsp_live_ff;
   logic             rsp_load;

   logic              ram_wr_en;
   logic [ROW_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ROW_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   logic [WORD_W-1:0] cur_word;
   logic [WORD_W-1:0] bit_mask;
   logic [BIT_W-1:0]  tgt_bit;
   logic [ROW_W-1:0]  tgt_row;
   logic [CNT_W-1:0]  tgt_base;
   logic [CNT_W-1:0]  scan_base;
   logic [CNT_W:0]    next_base;
   logic [CNT_W-1:0]  len_dec;
   logic              idx_ok;
   logic [OUT_W-1:0]  idx_cmp;
   logic [OUT_W-1:0]  granted_wide;
   logic [OUT_W-1:0]  len_wide;
   logic [OUT_W-1:0]  total_wide;

   find_req_type find_req;
   find_rsp_type find_rsp;

   function automatic logic [ROW_W-1:0] row_of(input logic [CNT_W-1:0] slot);
      return ROW_W'(slot >> BIT_W);
   endfunction

   lfsa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lfsa_find u_find (
      .find_req (find_req),
      .find_rsp (find_rsp)
   );

   // Decode the current target and map word
   assign cur_word  = rd_valid_ff ? ram_rd_data : '0;
   assign tgt_bit   = tgt_ff[BIT_W-1:0];
   assign tgt_row   = row_of(tgt_ff);
   assign bit_mask  = WORD_W'(1) << tgt_bit;
   assign tgt_base  = CNT_W'({tgt_row, BIT_W'(0)});
   assign scan_base = CNT_W'({scan_row_ff, BIT_W'(0)});
   assign len_dec   = len_ff - CNT_W'(1);
   assign idx_cmp   = OUT_W'(req_bus.slot_index);
   assign idx_ok    = idx_cmp < SLOTS_WIDE;

   // Feed the search unit from the word in hand
   always_comb begin
      find_req.limit = len_ff;
      if (state_ff == ST_SCAN) begin
         find_req.word  = cur_word;
         find_req.base  = scan_base;
         find_req.start = '0;
         next_base      = {1'b0, scan_base} + (CNT_W + 1)'(WORD_W);
      end else begin
         find_req.word  = cur_word | bit_mask;
         find_req.base  = tgt_base;
         find_req.start = {1'b0, tgt_bit} + (BIT_W + 1)'(1);
         next_base      = {1'b0, tgt_base} + (CNT_W + 1)'(WORD_W);
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      status_in   = status_ff;
      append_in   = append_ff;
      tgt_in      = tgt_ff;
      scan_row_in = scan_row_ff;
      len_in      = len_ff;
      hint_in     = hint_ff;
      total_in    = total_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = tgt_row;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tgt_row;
      ram_wr_data = cur_word | bit_mask;
      rsp_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in    = command_type'(req_bus.command);
               status_in = STATUS_DONE;
               if (command_type'(req_bus.command) == CMD_ALLOC) begin
                  append_in = (hint_ff == NO_HINT);
                  if (hint_ff == NO_HINT && len_ff == NO_HINT) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     tgt_in      = (hint_ff == NO_HINT) ? len_ff : hint_ff;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = row_of(tgt_in);
                     state_in    = ST_MODIFY;
                  end
               end else if (idx_ok) begin
                  tgt_in      = CNT_W'(req_bus.slot_index);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = row_of(tgt_in);
                  state_in    = ST_MODIFY;
               end else begin
                  status_in = STATUS_NOT_OCCUPIED;
                  state_in  = ST_RESP;
               end
            end
         end

         ST_MODIFY: begin
            state_in = ST_RESP;
            if (cmd_ff == CMD_ALLOC) begin
               // Mark the slot taken
               ram_wr_en   = 1'b1;
               ram_wr_data = cur_word | bit_mask;
               total_in    = total_ff + CNT_W'(1);
               if (append_ff) begin
                  len_in = len_ff + CNT_W'(1);
               end else if (find_rsp.found) begin
                  hint_in = find_rsp.slot;
               end else begin
                  hint_in = NO_HINT;
                  if (next_base < {1'b0, len_ff}) begin
                     scan_row_in = tgt_row + ROW_W'(1);
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = scan_row_in;
                     state_in    = ST_SCAN;
                  end
               end
            end else if ((cur_word & bit_mask) == '0) begin
               status_in = STATUS_NOT_OCCUPIED;
            end else begin
               // Release the slot, trim or lower the hint
               ram_wr_en   = 1'b1;
               ram_wr_data = cur_word & ~bit_mask;
               total_in    = total_ff - CNT_W'(1);
               if (tgt_ff == len_dec) begin
                  len_in = len_dec;
                  if (hint_ff != NO_HINT && hint_ff >= len_dec) begin
                     hint_in = NO_HINT;
                  end
               end else if (tgt_ff < hint_ff) begin
                  hint_in = tgt_ff;
               end
            end
         end

         ST_SCAN: begin
            if (find_rsp.found) begin
               hint_in  = find_rsp.slot;
               state_in = ST_RESP;
            end else if (next_base < {1'b0, len_ff}) begin
               scan_row_in = scan_row_ff + ROW_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_row_in;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         hint_ff      <= NO_HINT;
         total_ff     <= '0;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         hint_ff  <= hint_in;
         total_ff <= total_in;
         if (ram_wr_en) begin
            row_valid_ff[ram_wr_addr] <= 1'b1;
         end
         if (ram_rd_en) begin
            rd_valid_ff <= row_valid_ff[ram_rd_addr];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request payload and response registers
   assign granted_wide = OUT_W'(tgt_ff);
   assign len_wide     = OUT_W'(len_ff);
   assign total_wide   = OUT_W'(total_ff);

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      status_ff   <= status_in;
      append_ff   <= append_in;
      tgt_ff      <= tgt_in;
      scan_row_ff <= scan_row_in;
      if (rsp_load) begin
         rsp_granted_ff <= (cmd_ff == CMD_ALLOC && status_ff == STATUS_DONE) ?
                           granted_wide[7:0] : 8'd0;
         rsp_status_ff  <= status_ff;
         rsp_used_ff    <= len_wide[8:0];
         rsp_live_ff    <= total_wide[8:0];
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.granted_slot = rsp_granted_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.used_length  = rsp_used_ff;
   assign rsp_bus.live_count   = rsp_live_ff;

endmodule

// ----- rtl/core/lfsa_checker.sv -----
// ----------------------------------------------------------------------------
// lfsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfsa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_granted_slot,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_used_length,
   input logic [8:0] rsp_live_count
);
   import lfsa_pkg::*;

   // A stalled response holds its payload
   `LFSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_granted_slot, rsp_status, rsp_used_length, rsp_live_count}))

   // Only the three defined status codes appear
   `LFSA_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status == STATUS_DONE || rsp_status == STATUS_FULL || rsp_status == STATUS_NOT_OCCUPIED)

   // Pool full means the length mark sits at capacity and nothing is granted
   `LFSA_ASSERT_IMPLY(a_full_shape, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_granted_slot == 8'd0 && rsp_used_length == FULL_LENGTH)

   // Occupied slots never exceed the length mark
   `LFSA_ASSERT_IMPLY(a_live_le_len, clock, reset, rsp_valid, rsp_live_count <= rsp_used_length)

   // One request at a time: busy right after an accept
   `LFSA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_granted_slot (rsp_bus.granted_slot),
   .rsp_status       (rsp_bus.status),
   .rsp_used_length  (rsp_bus.used_length),
   .rsp_live_count   (rsp_bus.live_count)
);
